[hw/rtl/mslc_pkg.sv]
// Shared constants, types and the CRC-16/Modbus byte step for the section level collector.
// No dependencies; imported by mslc_ctrl, mslc_datapath and the collector top level.
`default_nettype none

package mslc_pkg;

  localparam int MAX_SECTIONS    = 16;
  localparam int MAX_FRAME_BYTES = 64;
  localparam int MIN_FRAME_BYTES = 5;
  localparam int LEVEL_BYTE_POS  = 4;
  localparam int MM_PER_CM       = 10;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] LEVEL_SAT = 16'hFFFF;

  // register field widths
  localparam int SECT_CFG_W = 5;
  localparam int LEN_CFG_W  = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // derived widths
  localparam int SEC_CNT_W  = $clog2(MAX_SECTIONS + 1);
  localparam int SEC_IDX_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int FCNT_W     = $clog2(MAX_FRAME_BYTES + 2);
  localparam int FLEN_W     = $clog2(MAX_FRAME_BYTES + 3);
  localparam int SUM_W      = $clog2(MAX_SECTIONS * 255 + 1);
  localparam int LIM_W      = SEC_CNT_W + LEN_CFG_W;
  localparam int CMP_W      = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam int MM_FULL_W  = (SUM_W + 4 > 16) ? SUM_W + 4 : 16;

  // register indexes (paddr bit 2)
  localparam logic REG_SECTIONS = 1'b0;
  localparam logic REG_LENGTH   = 1'b1;

  // input modes and result kinds
  localparam logic MODE_BYTE     = 1'b0;
  localparam logic MODE_FINISH   = 1'b1;
  localparam logic KIND_VERDICT  = 1'b0;
  localparam logic KIND_REPORT   = 1'b1;

  typedef struct packed {
    logic byte_take;     // accepted response byte
    logic verdict_load;  // accepted byte closes a frame: load verdict
    logic walk_start;    // clear sum and section index
    logic walk_step;     // add one section level
    logic report_load;   // load level report into output register
  } mslc_cmd_t;

  typedef struct packed {
    logic walk_done;     // section index reached the section count
  } mslc_status_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mslc_in_if.sv]
// Input channel: valid/ready handshake carrying one response byte or a finish request.
// Depends on nothing.
`default_nettype none

interface mslc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, mode, rx_byte, last_byte, input ready);
  modport sink   (input valid, mode, rx_byte, last_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/mslc_out_if.sv]
// Result channel: valid/ready handshake carrying a frame verdict or a level report.
// Depends on nothing.
`default_nettype none

interface mslc_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic        frame_ok;
  logic [7:0]  section_id;
  logic        section_stored;
  logic [7:0]  section_value;
  logic [15:0] level_mm;
  logic        over_range;

  modport source (output valid, result_kind, frame_ok, section_id, section_stored,
                  section_value, level_mm, over_range, input ready);
  modport sink   (input valid, result_kind, frame_ok, section_id, section_stored,
                  section_value, level_mm, over_range, output ready);
endinterface

`default_nettype wire

[hw/rtl/mslc_ctrl.sv]
// Controller FSM: input/output handshake, frame-end verdict and finish-walk sequencing.
// Depends on mslc_pkg.
`default_nettype none

module mslc_ctrl
  import mslc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_mode,
  input  wire logic         in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  mslc_status_t      status,
  output mslc_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   in_acc;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_FINISH) begin
            cmd.walk_start = 1'b1;
            state_nxt      = ST_WALK;
          end else begin
            cmd.byte_take = 1'b1;
            if (in_last) begin
              cmd.verdict_load = 1'b1;
              out_valid_nxt    = 1'b1;
            end
          end
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          state_nxt = ST_REPORT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          cmd.report_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mslc_datapath.sv]
// Datapath: frame CRC and byte tracking, section level store, level sum and report math.
// Depends on mslc_pkg; driven by mslc_ctrl commands.
`default_nettype none

module mslc_datapath
  import mslc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  mslc_cmd_t                  cmd,
  output mslc_status_t               status,
  input  wire logic [SECT_CFG_W-1:0] sections_in_use,
  input  wire logic [LEN_CFG_W-1:0]  section_length_cm,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  last_byte,
  output logic                       result_kind,
  output logic                       frame_ok,
  output logic [7:0]                 section_id,
  output logic                       section_stored,
  output logic [7:0]                 section_value,
  output logic [15:0]                level_mm,
  output logic                       over_range
);

  // frame state
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        held0_r, held0_nxt, held1_r, held1_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [7:0]        faddr_r, faddr_nxt, flvl_r, flvl_nxt;

  // section store, entry i holds section i+1
  logic [7:0] levels_r [MAX_SECTIONS];

  // finish walk
  logic [SEC_CNT_W-1:0] idx_r;
  logic [SUM_W-1:0]     sum_r;

  // output payload
  logic        kind_r, ok_r, stored_r, over_r;
  logic [7:0]  id_r, value_r;
  logic [15:0] mm_r;

  logic [SEC_CNT_W-1:0] eff;
  logic [7:0]           addr_cur, lvl_cur;
  logic [FLEN_W-1:0]    flen;
  logic [15:0]          crc_fin;
  logic                 crc_ok, len_ok, store_hit;
  logic [SEC_IDX_W-1:0] store_idx;
  logic [LIM_W-1:0]     limit;
  logic                 over_cur;
  logic [MM_FULL_W-1:0] mm_full;
  logic [15:0]          mm_cur;

  assign eff = (32'(sections_in_use) > 32'(MAX_SECTIONS)) ? SEC_CNT_W'(MAX_SECTIONS)
                                                          : SEC_CNT_W'(sections_in_use);

  assign addr_cur = (fcnt_r == FCNT_W'(0)) ? rx_byte : faddr_r;
  assign lvl_cur  = (fcnt_r == FCNT_W'(LEVEL_BYTE_POS)) ? rx_byte : flvl_r;

  assign flen    = FLEN_W'(fcnt_r) + FLEN_W'(1);
  assign len_ok  = (flen >= FLEN_W'(MIN_FRAME_BYTES)) && (flen <= FLEN_W'(MAX_FRAME_BYTES));
  assign crc_fin = crc_feed(crc_r, held1_r);
  assign crc_ok  = len_ok && (crc_fin == {rx_byte, held0_r});
  assign store_hit = crc_ok && (addr_cur != 8'd0) && (32'(addr_cur) <= 32'(eff));
  assign store_idx = SEC_IDX_W'(addr_cur - 8'd1);

  // frame byte tracking
  always_comb begin
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    fcnt_nxt  = fcnt_r;
    faddr_nxt = faddr_r;
    flvl_nxt  = flvl_r;
    if (cmd.byte_take) begin
      if (last_byte) begin
        crc_nxt   = CRC_INIT;
        held0_nxt = 8'd0;
        held1_nxt = 8'd0;
        fcnt_nxt  = '0;
        faddr_nxt = 8'd0;
        flvl_nxt  = 8'd0;
      end else begin
        faddr_nxt = addr_cur;
        flvl_nxt  = lvl_cur;
        if (fcnt_r >= FCNT_W'(2)) begin
          crc_nxt = crc_fin;
        end
        held1_nxt = held0_r;
        held0_nxt = rx_byte;
        if (fcnt_r <= FCNT_W'(MAX_FRAME_BYTES)) begin
          fcnt_nxt = fcnt_r + FCNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      held0_r <= 8'd0;
      held1_r <= 8'd0;
      fcnt_r  <= '0;
      faddr_r <= 8'd0;
      flvl_r  <= 8'd0;
    end else begin
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
      fcnt_r  <= fcnt_nxt;
      faddr_r <= faddr_nxt;
      flvl_r  <= flvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        levels_r[i] <= 8'd0;
      end
    end else if (cmd.verdict_load && store_hit) begin
      levels_r[store_idx] <= lvl_cur;
    end
  end

  // level sum over sections, one per cycle
  assign status.walk_done = (idx_r == eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      sum_r <= '0;
    end else if (cmd.walk_start) begin
      idx_r <= '0;
      sum_r <= '0;
    end else if (cmd.walk_step) begin
      idx_r <= idx_r + SEC_CNT_W'(1);
      sum_r <= sum_r + SUM_W'(levels_r[SEC_IDX_W'(idx_r)]);
    end
  end

  assign limit    = LIM_W'(eff) * LIM_W'(section_length_cm);
  assign over_cur = (CMP_W'(sum_r) >= CMP_W'(limit));
  // x10 as shift-add
  assign mm_full  = (MM_FULL_W'(sum_r) << 3) + (MM_FULL_W'(sum_r) << 1);
  assign mm_cur   = (mm_full > MM_FULL_W'(LEVEL_SAT)) ? LEVEL_SAT : 16'(mm_full);

  always_ff @(posedge clk) begin
    if (cmd.verdict_load) begin
      kind_r   <= KIND_VERDICT;
      ok_r     <= crc_ok;
      id_r     <= addr_cur;
      stored_r <= store_hit;
      value_r  <= lvl_cur;
      mm_r     <= 16'd0;
      over_r   <= 1'b0;
    end else if (cmd.report_load) begin
      kind_r   <= KIND_REPORT;
      ok_r     <= 1'b0;
      id_r     <= 8'd0;
      stored_r <= 1'b0;
      value_r  <= 8'd0;
      mm_r     <= over_cur ? 16'd0 : mm_cur;
      over_r   <= over_cur;
    end
  end

  assign result_kind    = kind_r;
  assign frame_ok       = ok_r;
  assign section_id     = id_r;
  assign section_stored = stored_r;
  assign section_value  = value_r;
  assign level_mm       = mm_r;
  assign over_range     = over_r;

endmodule

`default_nettype wire

[hw/rtl/modbus_section_level_collector.sv]
// Modbus RTU response checker and section level collector: for each response byte the
// CRC-16/Modbus step is unrolled over 8 bits in combinational logic; a frame's last byte loads its
// verdict into the output register at the accept edge. A finish transaction walks the
// section store one section a cycle, then waits for a free output slot to load the report.
// Synchronous active-low reset: frame state, section levels zero, sections 1, length 100.
`default_nettype none

module modbus_section_level_collector
  import mslc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // response byte / finish channel
  mslc_in_if.sink                    in_chan,
  // verdict / report channel
  mslc_out_if.source                 out_chan,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  // Config registers. paddr[2] picks the register; low address bits are byte offsets.
  logic [SECT_CFG_W-1:0] sections_r;
  logic [LEN_CFG_W-1:0]  length_r;
  logic                  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sections_r <= SECT_CFG_W'(1);
      length_r   <= LEN_CFG_W'(100);
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SECTIONS) begin
        sections_r <= cfg_pwdata[SECT_CFG_W-1:0];
      end else begin
        length_r <= cfg_pwdata[LEN_CFG_W-1:0];
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SECTIONS: cfg_prdata = CFG_DATA_W'(sections_r);
      REG_LENGTH:   cfg_prdata = CFG_DATA_W'(length_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Controller <-> datapath
  mslc_cmd_t    cmd;
  mslc_status_t status;

  // The controller owns the handshakes; input accepts only in idle and when the
  // output register is free or being drained this cycle.
  mslc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_mode   (in_chan.mode),
    .in_last   (in_chan.last_byte),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  mslc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .sections_in_use   (sections_r),
    .section_length_cm (length_r),
    .rx_byte           (in_chan.rx_byte),
    .last_byte         (in_chan.last_byte),
    .result_kind       (out_chan.result_kind),
    .frame_ok          (out_chan.frame_ok),
    .section_id        (out_chan.section_id),
    .section_stored    (out_chan.section_stored),
    .section_value     (out_chan.section_value),
    .level_mm          (out_chan.level_mm),
    .over_range        (out_chan.over_range)
  );

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking bench for modbus_section_level_collector: Modbus response frames and finish
// transactions in, frame verdicts and level reports out, checked against an in-bench predictor.
// Depends on mslc_pkg, mslc_in_if, mslc_out_if and the collector RTL.
`timescale 1ns / 1ps

module testbench
  import mslc_pkg::*;
();

  // ---------------------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------------------
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 205;            // ~1250 transactions with the directed part
  localparam int PRESSURE_PHASE = 4;
  localparam int HOLD_CYCLES    = 300;            // long receiver hold-off
  localparam int SETTLE_CYCLES  = MAX_SECTIONS + 4; // finish walk plus slack
  localparam int WATCHDOG_LIMIT = 4000;           // cycles without any transaction

  // one input transaction
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       last;
  } probe_item_t;

  // one result transaction, same field order as the output channel
  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [7:0]  id;
    logic        stored;
    logic [7:0]  value;
    logic [15:0] mm;
    logic        over;
  } collector_result_t;

  // a typed-in expectation travels with its transaction to the accept edge
  typedef struct packed {
    bit                pinned;
    collector_result_t want;
  } pin_entry_t;

  // directed table: CRC rows send the running frame CRC xor the data column
  typedef enum logic [1:0] {ROW_BYTE, ROW_CRC_LO, ROW_CRC_HI, ROW_FINISH} row_op_e;

  typedef struct packed {
    row_op_e           op;
    logic [7:0]        data;
    logic              last;
    bit                pinned;
    collector_result_t want;
  } dir_row_t;

  function automatic collector_result_t mk_verdict(input logic ok, input logic [7:0] id,
                                                   input logic stored, input logic [7:0] value);
    collector_result_t r;
    r        = '0;
    r.kind   = KIND_VERDICT;
    r.ok     = ok;
    r.id     = id;
    r.stored = stored;
    r.value  = value;
    return r;
  endfunction

  function automatic collector_result_t mk_report(input logic [15:0] mm, input logic over);
    collector_result_t r;
    r      = '0;
    r.kind = KIND_REPORT;
    r.mm   = mm;
    r.over = over;
    return r;
  endfunction

  localparam collector_result_t NO_RESULT = '0;
  localparam int DIR_ROWS = 24;

  // Runs at reset config: 1 section, 100 cm.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // finish right after reset: empty store, nothing over range
    '{ROW_FINISH, 8'h00, 1'b0, 1'b1, mk_report(16'd0, 1'b0)},
    // one-byte frame, all-ones address
    '{ROW_BYTE,   8'hFF, 1'b1, 1'b1, mk_verdict(1'b0, 8'hFF, 1'b0, 8'h00)},
    // two-byte frame, all-zero bytes
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h00, 1'b1, 1'b1, mk_verdict(1'b0, 8'h00, 1'b0, 8'h00)},
    // good frame to section 1, full-scale level byte
    '{ROW_BYTE,   8'h01, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h03, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h02, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_HI, 8'h00, 1'b1, 1'b1, mk_verdict(1'b1, 8'h01, 1'b1, 8'hFF)},
    // 255 cm against a 100 cm section: over range
    '{ROW_FINISH, 8'hFF, 1'b1, 1'b1, mk_report(16'd0, 1'b1)},
    // four bytes with a valid CRC is still too short
    '{ROW_BYTE,   8'h02, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h03, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_HI, 8'h00, 1'b1, 1'b1, mk_verdict(1'b0, 8'h02, 1'b0, 8'h00)},
    // finish in the middle of a frame, then the frame carries on (address 0: never stored)
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h03, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h02, 1'b0, 1'b0, NO_RESULT},
    '{ROW_FINISH, 8'h00, 1'b0, 1'b1, mk_report(16'd0, 1'b1)},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE,   8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_LO, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_CRC_HI, 8'h00, 1'b1, 1'b1, mk_verdict(1'b1, 8'h00, 1'b0, 8'h00)}
  };

  // plan per phase; the last phase picks a random setting
  localparam int SECT_PLAN [PHASES] = '{16, 0, 31, 5, 16, 1};
  localparam int LEN_PLAN  [PHASES] = '{255, 100, 1, 0, 40, 1};

  // ---------------------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // ---------------------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  mslc_in_if  in_chan ();
  mslc_out_if out_chan ();

  modbus_section_level_collector uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor state: its own copy of frame state, section store and registers
  // ---------------------------------------------------------------------------------------
  logic [4:0]  cfg_sections;
  logic [7:0]  cfg_length;
  logic [15:0] crc_acc;
  logic [7:0]  trail [2];        // [0] newest byte, [1] the one before
  int          frm_count;        // saturates at MAX_FRAME_BYTES + 1
  logic [7:0]  frm_addr;
  logic [7:0]  frm_level;
  logic [7:0]  lvl_store [MAX_SECTIONS + 1];  // entry 0 unused

  collector_result_t expect_q [$];   // results still owed by the DUT
  pin_entry_t        pin_q    [$];   // one per offered transaction, popped on accept

  int  error_count;
  int  items_sent;
  int  stall_cycles;
  int  send_gap_pct;
  int  recv_stall_pct;
  int  hold_left;
  bit  hold_req;

  // CRC-16/Modbus, bit serial, LSB first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // register values above MAX_SECTIONS clamp
  function automatic int active_sections();
    return (cfg_sections > MAX_SECTIONS) ? MAX_SECTIONS : int'(cfg_sections);
  endfunction

  task automatic clear_frame_state();
    crc_acc   = CRC_INIT;
    trail[0]  = 8'h00;
    trail[1]  = 8'h00;
    frm_count = 0;
    frm_addr  = 8'h00;
    frm_level = 8'h00;
  endtask

  task automatic reset_collector_model();
    cfg_sections = 5'd1;
    cfg_length   = 8'd100;
    clear_frame_state();
    for (int s = 0; s <= MAX_SECTIONS; s++) begin
      lvl_store[s] = 8'h00;
    end
  endtask

  // Advance predictor by one accepted transaction; has_result tells whether one is owed.
  task automatic predict_collector(input probe_item_t it, output bit has_result,
                                   output collector_result_t res);
    int   eff;
    int   sum;
    int   mm;
    int   frame_len;
    logic ok;
    eff        = active_sections();
    res        = '0;
    has_result = 1'b0;
    if (it.mode == MODE_FINISH) begin
      // level report; an open frame is left untouched
      sum = 0;
      for (int s = 1; s <= eff; s++) begin
        sum += lvl_store[s];
      end
      res.kind   = KIND_REPORT;
      has_result = 1'b1;
      if (sum >= eff * int'(cfg_length)) begin
        res.over = 1'b1;
      end else begin
        mm     = sum * MM_PER_CM;
        res.mm = (mm > 16'hFFFF) ? LEVEL_SAT : mm[15:0];
      end
    end else begin
      if (frm_count == 0) begin
        frm_addr = it.data;
      end
      if (frm_count == LEVEL_BYTE_POS) begin
        frm_level = it.data;
      end
      if (!it.last) begin
        // CRC runs two bytes behind so the trailer never enters it
        if (frm_count >= 2) begin
          crc_acc = modbus_crc_byte(crc_acc, trail[1]);
        end
        trail[1] = trail[0];
        trail[0] = it.data;
        if (frm_count <= MAX_FRAME_BYTES) begin
          frm_count++;
        end
      end else begin
        frame_len = frm_count + 1;
        ok        = 1'b0;
        if (frame_len >= MIN_FRAME_BYTES && frame_len <= MAX_FRAME_BYTES) begin
          ok = (modbus_crc_byte(crc_acc, trail[1]) == {it.data, trail[0]});
        end
        res.kind   = KIND_VERDICT;
        res.ok     = ok;
        res.id     = frm_addr;
        res.value  = frm_level;
        res.stored = ok && frm_addr >= 1 && int'(frm_addr) <= eff;
        if (res.stored) begin
          lvl_store[frm_addr] = frm_level;
        end
        has_result = 1'b1;
        clear_frame_state();
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  // Everything is sampled at the rising edge. The output side is checked first so a
  // transaction accepted on the same edge can never be matched against its own result.
  always @(posedge clk) begin : track_transactions
    probe_item_t       item;
    collector_result_t got;
    collector_result_t want;
    collector_result_t pred;
    pin_entry_t        pin;
    bit                has_pred;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.result_kind, out_chan.frame_ok, out_chan.section_id,
                out_chan.section_stored, out_chan.section_value, out_chan.level_mm,
                out_chan.over_range};
        if (expect_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: kind %0d id %0d",
                                    got.kind, got.id));
        end else begin
          want = expect_q.pop_front();
          check_field("result_kind",    got.kind,   want.kind);
          check_field("frame_ok",       got.ok,     want.ok);
          check_field("section_id",     got.id,     want.id);
          check_field("section_stored", got.stored, want.stored);
          check_field("section_value",  got.value,  want.value);
          check_field("level_mm",       got.mm,     want.mm);
          check_field("over_range",     got.over,   want.over);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        item = '{in_chan.mode, in_chan.rx_byte, in_chan.last_byte};
        predict_collector(item, has_pred, pred);
        pin = pin_q.pop_front();
        if (pin.pinned) begin
          expect_q.push_back(pin.want);
        end else if (has_pred) begin
          expect_q.push_back(pred);
        end
      end
    end
  end

  // Watchdog: any transaction on any port counts as progress.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off when asked; counted here.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  // Offer one transaction from the falling edge, with random sender gaps first, and
  // hold it until accepted. valid stays up for the next call, so the caller drops it.
  task automatic send_item(input logic mode, input logic [7:0] data, input logic last,
                           input bit pinned = 1'b0, input collector_result_t want = '0);
    pin_entry_t e;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    e.pinned = pinned;
    e.want   = want;
    pin_q.push_back(e);
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= mode;
    in_chan.rx_byte   <= data;
    in_chan.last_byte <= last;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  // Drop valid, wait until every owed result is in, then let a finish walk run out.
  task automatic wait_quiet();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expect_q.size() != 0 || pin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with a setup and an access phase; upper data bits are junk the register must ignore.
  task automatic write_reg(input logic reg_sel, input int unsigned value);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom();
    if (reg_sel == REG_SECTIONS) begin
      data[SECT_CFG_W-1:0] = value[SECT_CFG_W-1:0];
    end else begin
      data[LEN_CFG_W-1:0] = value[LEN_CFG_W-1:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == REG_SECTIONS) begin
      cfg_sections = data[SECT_CFG_W-1:0];
    end else begin
      cfg_length = data[LEN_CFG_W-1:0];
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly live sections, some address 0 and some beyond the active count.
  function automatic logic [7:0] pick_addr();
    int eff;
    int p;
    eff = active_sections();
    p   = $urandom_range(99);
    if (p < 10) begin
      return 8'h00;
    end
    if (p < 20 || eff == 0) begin
      return 8'($urandom_range(255, eff + 1));
    end
    return 8'($urandom_range(eff, 1));
  endfunction

  // Short frames dominate; now and then a long one and the buffer limit itself.
  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 80) begin
      return $urandom_range(12, MIN_FRAME_BYTES);
    end
    if (p < 95) begin
      return $urandom_range(MAX_FRAME_BYTES - 1, 13);
    end
    return MAX_FRAME_BYTES;
  endfunction

  // Response frame: address, function 03, byte count, data, CRC trailer.
  // A bad frame gets one flipped bit, which CRC-16 always catches.
  // finish_at >= 0 slips a finish transaction in before that byte.
  task automatic send_frame(input logic [7:0] addr, input int len, input bit good,
                            input int finish_at);
    logic [7:0]  bytes [$];
    logic [15:0] crc;
    int          flip;
    bytes.push_back(addr);
    for (int i = 1; i < len; i++) begin
      bytes.push_back((i == 1) ? 8'h03 : (i == 2) ? 8'(len - MIN_FRAME_BYTES) : 8'($urandom));
    end
    // keep half the level bytes within one section length so sums stay in range
    if (len >= LEVEL_BYTE_POS + 3 && $urandom_range(1)) begin
      bytes[LEVEL_BYTE_POS] = 8'($urandom_range(int'(cfg_length)));
    end
    if (len >= 3) begin
      crc = CRC_INIT;
      for (int i = 0; i < len - 2; i++) begin
        crc = modbus_crc_byte(crc, bytes[i]);
      end
      bytes[len-2] = crc[7:0];
      bytes[len-1] = crc[15:8];
    end
    if (!good) begin
      flip        = $urandom_range(len - 1);
      bytes[flip] = bytes[flip] ^ 8'(1 << $urandom_range(7));
    end
    for (int i = 0; i < len; i++) begin
      if (i == finish_at) begin
        send_item(MODE_FINISH, 8'($urandom), 1'($urandom_range(1)));
      end
      send_item(MODE_BYTE, bytes[i], i == len - 1);
    end
  endtask

  // One random burst: mostly clean frames, the rest finishes, damage and noise.
  task automatic send_random_burst();
    int p;
    int len;
    p = $urandom_range(99);
    if (p < 55) begin
      send_frame(pick_addr(), pick_len(), 1'b1, -1);
    end else if (p < 65) begin
      send_frame(pick_addr(), pick_len(), 1'b0, -1);
    end else if (p < 75) begin
      send_item(MODE_FINISH, 8'($urandom), 1'($urandom_range(1)));
    end else if (p < 82) begin
      send_frame(pick_addr(), $urandom_range(MIN_FRAME_BYTES - 1, 1), 1'b1, -1);
    end else if (p < 85) begin
      // past the buffer; byte count saturates
      send_frame(pick_addr(), $urandom_range(MAX_FRAME_BYTES + 6, MAX_FRAME_BYTES + 1),
                 1'($urandom_range(1)), -1);
    end else if (p < 92) begin
      len = pick_len();
      send_frame(pick_addr(), len, 1'b1, $urandom_range(len - 1, 1));
    end else begin
      // stray bytes, occasionally ending a frame of their own
      repeat ($urandom_range(6, 1)) begin
        send_item(MODE_BYTE, 8'($urandom), $urandom_range(7) == 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------
  initial begin : run_test
    dir_row_t    row;
    logic [15:0] walk_crc;
    int          target;
    int          sect_set;
    int          len_set;

    clk               = 1'b0;
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.mode      = MODE_BYTE;
    in_chan.rx_byte   = 8'h00;
    in_chan.last_byte = 1'b0;
    out_chan.ready    = 1'b0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    error_count       = 0;
    items_sent        = 0;
    stall_cycles      = 0;
    hold_left         = 0;
    hold_req          = 1'b0;
    send_gap_pct      = 19;
    recv_stall_pct    = 48;
    reset_collector_model();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed part at reset config
    walk_crc = CRC_INIT;
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      case (row.op)
        ROW_FINISH: begin
          send_item(MODE_FINISH, row.data, row.last, row.pinned, row.want);
        end
        ROW_BYTE: begin
          send_item(MODE_BYTE, row.data, row.last, row.pinned, row.want);
          walk_crc = row.last ? CRC_INIT : modbus_crc_byte(walk_crc, row.data);
        end
        ROW_CRC_LO: begin
          send_item(MODE_BYTE, walk_crc[7:0] ^ row.data, 1'b0, row.pinned, row.want);
        end
        ROW_CRC_HI: begin
          send_item(MODE_BYTE, walk_crc[15:8] ^ row.data, 1'b1, row.pinned, row.want);
          walk_crc = CRC_INIT;
        end
      endcase
    end

    // random phases; config only changes once the block has gone quiet
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_quiet();
      sect_set = (phase == PHASES - 1) ? $urandom_range(MAX_SECTIONS, 1) : SECT_PLAN[phase];
      len_set  = (phase == PHASES - 1) ? $urandom_range(255, 1) : LEN_PLAN[phase];
      write_reg(REG_SECTIONS, sect_set);
      write_reg(REG_LENGTH, len_set);
      // idling: sender light / receiver heavy, then swapped, then none
      send_gap_pct   = (phase < 2) ? 19 : (phase < 4) ? 48 : 0;
      recv_stall_pct = (phase < 2) ? 48 : (phase < 4) ? 19 : 0;
      target = items_sent + PHASE_ITEMS;
      if (phase == PRESSURE_PHASE) begin
        // receiver goes dark while frames keep coming: output fills, input must stall
        hold_req = 1'b1;
        repeat (12) send_frame(pick_addr(), $urandom_range(8, MIN_FRAME_BYTES), 1'b1, -1);
      end
      while (items_sent < target) begin
        send_random_burst();
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
